@@ hw/rtl/pbsv_pkg.sv @@
// Shared constants and types of the polyline Biot-Savart velocity block.
package pbsv_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int FRAC_BITS  = 16;
	localparam int AW         = $clog2(MAX_POINTS);
	localparam int CW         = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 32;
	localparam int PT_W       = 3 * COORD_W;
	localparam int SUM_W      = AW + 37;

	localparam logic signed [31:0] INV_4PI_Q30 = 32'sd85445659;
	localparam logic [63:0] TERM_CAP = 64'd1 << 35;
	localparam logic [63:0] M_LIM    = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;
	localparam logic signed [68:0] LIM31 = 69'sd2147483647;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	typedef logic [2:0][COORD_W-1:0] point_t;

endpackage

@@ hw/rtl/pbsv_stream_if.sv @@
// Input and result stream interfaces of the polyline Biot-Savart velocity block.
interface pbsv_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] coord_x;
	logic [31:0] coord_y;
	logic [31:0] coord_z;

	modport source (output valid, command, coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, command, coord_x, coord_y, coord_z, output ready);
endinterface

interface pbsv_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] vel_x;
	logic [31:0] vel_y;
	logic [31:0] vel_z;
	logic        singular_seen;
	logic        saturated;
	logic        store_full;

	modport source (output valid, vel_x, vel_y, vel_z, singular_seen, saturated, store_full,
		input ready);
	modport sink (input valid, vel_x, vel_y, vel_z, singular_seen, saturated, store_full,
		output ready);
endinterface

@@ hw/rtl/pbsv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pbsv_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/pbsv_div.sv @@
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module pbsv_div import pbsv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic        ge;

	assign shifted = {rem_q, dvd_q[63]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			dvd_q <= {dvd_q[62:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

@@ hw/rtl/polyline_biot_savart_velocity.sv @@
// Top level: velocity induced at a target by a closed vortex polyline.
// Clear and load leave the block idle; a load into a full store is dropped.
// A query walks every stored segment, running up to three chained divides per component
// on the shared 64-bit bit-serial divider (fewer when a term caps early, none for a
// skipped segment); input is not ready meanwhile.
// Reset clears the point count, the sequencer and the result valid flag and
// sets circulation to 1.0; the point store holds no reset and needs no sweep.
module polyline_biot_savart_velocity import pbsv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	pbsv_in_if.sink     in_ch,
	pbsv_out_if.source  out_ch
);

	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_RD0   = 18'h00002,
		S_LD0   = 18'h00004,
		S_LDN   = 18'h00008,
		S_DIFF  = 18'h00010,
		S_MUL   = 18'h00020,
		S_ACC   = 18'h00040,
		S_CHK   = 18'h00080,
		S_SQRT  = 18'h00100,
		S_DIV_A = 18'h00200,
		S_DIV_W = 18'h00400,
		S_TERM  = 18'h00800,
		S_NEXT  = 18'h01000,
		S_P_MUL = 18'h02000,
		S_P_RND = 18'h04000,
		S_V_MUL = 18'h08000,
		S_V_RND = 18'h10000,
		S_DONE  = 18'h20000
	} state_t;

	function automatic logic [32:0] clamp_diff(input logic [31:0] a, input logic [31:0] b);
		logic signed [32:0] d;
		d = $signed({a[31], a}) - $signed({b[31], b});
		if (d > 33'sd2147483647) begin
			return {1'b1, 32'h7FFF_FFFF};
		end else if (d < -33'sd2147483647) begin
			return {1'b1, 32'h8000_0001};
		end
		return {1'b0, d[31:0]};
	endfunction

	function automatic logic signed [68:0] rnd_shift(input logic signed [68:0] v, input int sh);
		logic [68:0] m;
		m = v[68] ? 69'(-v) : 69'(v);
		m = (m + (69'd1 << (sh - 1))) >> sh;
		return v[68] ? -$signed(m) : $signed(m);
	endfunction

	state_t state_q;

	logic [CW-1:0]           count_q;
	logic signed [31:0]      circ_q;
	logic [AW-1:0]           idx_q;
	point_t                  tgt_q, p0_q, cur_q, nxt_q;
	logic signed [31:0]      dl_q [3];
	logic signed [31:0]      r_q [3];
	logic [3:0]              mcnt_q;
	logic signed [68:0]      prod_q;
	logic [63:0]             rr_q;
	logic signed [63:0]      c_q [3];
	logic [63:0]             sx_q, sres_q, sbit_q;
	logic [4:0]              scnt_q;
	logic [1:0]              acnt_q;
	logic [1:0]              kcnt_q;
	logic [63:0]             m_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [28:0]      p_q;
	logic [31:0]             vel_q [3];
	logic                    sing_q, sat_q;

	logic        ovalid_q;
	logic [31:0] ovx_q, ovy_q, ovz_q;
	logic        osing_q, osat_q, ofull_q;

	logic               ram_we;
	logic [AW-1:0]      raddr;
	point_t             rdata;
	point_t             in_pt;
	logic signed [36:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [68:0] mul_p;
	logic               div_start;
	logic [63:0]        div_dvd;
	logic               div_done;
	logic [63:0]        div_q;
	logic [63:0]        cabs;
	logic signed [36:0] sclamp;
	logic               sclamp_flag;
	logic [63:0]        sq_t;
	logic               in_acc;
	logic               more;
	logic               out_load;

	assign in_pt  = {in_ch.coord_z, in_ch.coord_y, in_ch.coord_x};
	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign ram_we = in_acc && (in_ch.command == CMD_LOAD) && (count_q < CW'(MAX_POINTS));
	assign more   = ({1'b0, idx_q} + CW'(1)) < count_q;
	assign cabs   = c_q[acnt_q][63] ? 64'(-c_q[acnt_q]) : 64'(c_q[acnt_q]);
	assign sq_t   = sres_q + sbit_q;
	assign out_load = (state_q == S_DONE) && (!ovalid_q || out_ch.ready);

	pbsv_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (in_pt),
		.raddr (raddr),
		.rdata (rdata)
	);

	pbsv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (sres_q[31:0]),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		raddr = '0;
		if (state_q == S_LD0) begin
			raddr = AW'(1);
		end else if (state_q == S_NEXT) begin
			raddr = idx_q + AW'(2);
		end
	end

	always_comb begin
		sclamp_flag = 1'b0;
		if (sum_q[acnt_q] > $signed(SUM_W'(TERM_CAP))) begin
			sclamp = $signed(37'(TERM_CAP));
			sclamp_flag = 1'b1;
		end else if (sum_q[acnt_q] < -$signed(SUM_W'(TERM_CAP))) begin
			sclamp = -$signed(37'(TERM_CAP));
			sclamp_flag = 1'b1;
		end else begin
			sclamp = 37'(sum_q[acnt_q]);
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MUL: begin
				case (mcnt_q)
					4'd0: begin mul_a = 37'(r_q[0]);  mul_b = r_q[0]; end
					4'd1: begin mul_a = 37'(r_q[1]);  mul_b = r_q[1]; end
					4'd2: begin mul_a = 37'(r_q[2]);  mul_b = r_q[2]; end
					4'd3: begin mul_a = 37'(dl_q[1]); mul_b = r_q[2]; end
					4'd4: begin mul_a = 37'(dl_q[2]); mul_b = r_q[1]; end
					4'd5: begin mul_a = 37'(dl_q[2]); mul_b = r_q[0]; end
					4'd6: begin mul_a = 37'(dl_q[0]); mul_b = r_q[2]; end
					4'd7: begin mul_a = 37'(dl_q[0]); mul_b = r_q[1]; end
					default: begin mul_a = 37'(dl_q[1]); mul_b = r_q[0]; end
				endcase
			end
			S_P_MUL: begin
				mul_a = 37'(circ_q);
				mul_b = INV_4PI_Q30;
			end
			S_V_MUL: begin
				mul_a = sclamp;
				mul_b = 32'(p_q);
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		div_start = 1'b0;
		div_dvd   = cabs;
		if (state_q == S_DIV_A) begin
			div_start = 1'b1;
		end else if (state_q == S_DIV_W && div_done && kcnt_q != 2'd2 && div_q <= M_LIM) begin
			div_start = 1'b1;
			div_dvd   = div_q << FRAC_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			circ_q   <= 32'sd65536;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				circ_q <= $signed(cfg_data);
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (in_ch.command)
							CMD_CLEAR: count_q <= '0;
							CMD_LOAD: begin
								if (ram_we) begin
									count_q <= count_q + CW'(1);
								end
							end
							CMD_QUERY: state_q <= (count_q == '0) ? S_P_MUL : S_RD0;
							default: ;
						endcase
					end
				end
				S_RD0:   state_q <= S_LD0;
				S_LD0:   state_q <= S_LDN;
				S_LDN:   state_q <= S_DIFF;
				S_DIFF:  state_q <= S_MUL;
				S_MUL:   state_q <= S_ACC;
				S_ACC:   state_q <= (mcnt_q == 4'd8) ? S_CHK : S_MUL;
				S_CHK:   state_q <= (rr_q == '0) ? S_NEXT : S_SQRT;
				S_SQRT:  state_q <= (scnt_q == 5'd31) ? S_DIV_A : S_SQRT;
				S_DIV_A: state_q <= S_DIV_W;
				S_DIV_W: begin
					if (div_done && !div_start) begin
						state_q <= S_TERM;
					end
				end
				S_TERM:  state_q <= (acnt_q == 2'd2) ? S_NEXT : S_DIV_A;
				S_NEXT:  state_q <= more ? S_LDN : S_P_MUL;
				S_P_MUL: state_q <= S_P_RND;
				S_P_RND: state_q <= S_V_MUL;
				S_V_MUL: state_q <= S_V_RND;
				S_V_RND: state_q <= (acnt_q == 2'd2) ? S_DONE : S_V_MUL;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		logic [32:0]        cd;
		logic [63:0]        mt;
		logic signed [68:0] rv;
		prod_q <= mul_p;
		unique case (state_q)
			S_IDLE: begin
				tgt_q  <= in_pt;
				idx_q  <= '0;
				sing_q <= 1'b0;
				sat_q  <= 1'b0;
				for (int a = 0; a < 3; a++) begin
					sum_q[a] <= '0;
				end
			end
			S_LD0: begin
				p0_q  <= rdata;
				cur_q <= rdata;
			end
			S_LDN: nxt_q <= more ? rdata : p0_q;
			S_DIFF: begin
				for (int a = 0; a < 3; a++) begin
					cd = clamp_diff(nxt_q[a], cur_q[a]);
					dl_q[a] <= $signed(cd[31:0]);
					if (cd[32]) sat_q <= 1'b1;
					cd = clamp_diff(tgt_q[a], cur_q[a]);
					r_q[a] <= $signed(cd[31:0]);
					if (cd[32]) sat_q <= 1'b1;
				end
				rr_q   <= '0;
				mcnt_q <= '0;
			end
			S_ACC: begin
				mcnt_q <= mcnt_q + 4'd1;
				case (mcnt_q)
					4'd0, 4'd1, 4'd2: rr_q <= rr_q + prod_q[63:0];
					4'd3: c_q[0] <= prod_q[63:0];
					4'd4: c_q[0] <= c_q[0] - prod_q[63:0];
					4'd5: c_q[1] <= prod_q[63:0];
					4'd6: c_q[1] <= c_q[1] - prod_q[63:0];
					4'd7: c_q[2] <= prod_q[63:0];
					default: c_q[2] <= c_q[2] - prod_q[63:0];
				endcase
			end
			S_CHK: begin
				if (rr_q == '0) begin
					sing_q <= 1'b1;
				end
				sx_q   <= rr_q;
				sres_q <= '0;
				sbit_q <= 64'd1 << 62;
				scnt_q <= '0;
			end
			S_SQRT: begin
				if (sx_q >= sq_t) begin
					sx_q   <= sx_q - sq_t;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
				scnt_q <= scnt_q + 5'd1;
				acnt_q <= '0;
			end
			S_DIV_A: kcnt_q <= '0;
			S_DIV_W: begin
				if (div_done) begin
					if (div_start) begin
						kcnt_q <= kcnt_q + 2'd1;
					end else if (kcnt_q == 2'd2) begin
						m_q <= div_q;
					end else begin
						m_q   <= TERM_CAP;
						sat_q <= 1'b1;
					end
				end
			end
			S_TERM: begin
				mt = m_q;
				if (m_q > TERM_CAP) begin
					mt = TERM_CAP;
					sat_q <= 1'b1;
				end
				if (c_q[acnt_q][63]) begin
					sum_q[acnt_q] <= sum_q[acnt_q] - $signed(SUM_W'(mt));
				end else begin
					sum_q[acnt_q] <= sum_q[acnt_q] + $signed(SUM_W'(mt));
				end
				acnt_q <= acnt_q + 2'd1;
			end
			S_NEXT: begin
				idx_q <= idx_q + AW'(1);
				cur_q <= nxt_q;
			end
			S_P_RND: begin
				rv = rnd_shift(prod_q, 30);
				p_q    <= rv[28:0];
				acnt_q <= '0;
			end
			S_V_MUL: begin
				if (sclamp_flag) sat_q <= 1'b1;
			end
			S_V_RND: begin
				rv = rnd_shift(prod_q, FRAC_BITS);
				if (rv > LIM31) begin
					vel_q[acnt_q] <= 32'h7FFF_FFFF;
					sat_q <= 1'b1;
				end else if (rv < -LIM31) begin
					vel_q[acnt_q] <= 32'h8000_0001;
					sat_q <= 1'b1;
				end else begin
					vel_q[acnt_q] <= rv[31:0];
				end
				acnt_q <= acnt_q + 2'd1;
			end
			default: ;
		endcase
		if (out_load) begin
			ovx_q   <= vel_q[0];
			ovy_q   <= vel_q[1];
			ovz_q   <= vel_q[2];
			osing_q <= sing_q;
			osat_q  <= sat_q;
			ofull_q <= (count_q == CW'(MAX_POINTS));
		end
	end

	assign out_ch.valid         = ovalid_q;
	assign out_ch.vel_x         = ovx_q;
	assign out_ch.vel_y         = ovy_q;
	assign out_ch.vel_z         = ovz_q;
	assign out_ch.singular_seen = osing_q;
	assign out_ch.saturated     = osat_q;
	assign out_ch.store_full    = ofull_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond store depth");

	a_load_inc: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> count_q == $past(count_q) + CW'(1))
		else $error("load did not advance point count");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(state_q) == S_DONE)
		else $error("result beat raised outside completion");

	a_sqrt_nz: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQRT |-> rr_q != '0)
		else $error("square root entered on singular segment");

endmodule

@@ tb/sv/polyline_biot_savart_velocity_test.sv @@
// Testbench for the polyline Biot-Savart velocity block: predicts and checks every query result.
module polyline_biot_savart_velocity_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pbsv_pkg::*;

	typedef struct packed {
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic        sing;
		logic        sat;
		logic        full;
	} velocity_t;

	class velocity_scoreboard;
		longint       pts[MAX_POINTS][3];
		int           count;
		longint       circulation;
		bit           clamp_flag;
		velocity_t    expected[$];
		int           errors;

		function new();
			count = 0;
			circulation = longint'(1) << FRAC_BITS;
			errors = 0;
		endfunction

		function longint clamp(longint v, longint lim);
			if (v > lim) begin
				clamp_flag = 1;
				return lim;
			end
			if (v < -lim) begin
				clamp_flag = 1;
				return -lim;
			end
			return v;
		endfunction

		function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint round_shift(longint v, int sh);
			bit neg;
			longint unsigned m;
			neg = v < 0;
			m = neg ? 64'd0 - longint'(v) : v;
			m = (m + (64'd1 << (sh - 1))) >> sh;
			return neg ? -longint'(m) : longint'(m);
		endfunction

		function longint segment_term(longint c, longint unsigned rn);
			bit neg;
			longint unsigned m;
			neg = c < 0;
			m = neg ? 64'd0 - c : c;
			m = m / rn;
			for (int k = 0; k < 2; k++) begin
				if (m > M_LIM) begin
					m = TERM_CAP;
					clamp_flag = 1;
					break;
				end
				m = (m << FRAC_BITS) / rn;
			end
			if (m > TERM_CAP) begin
				m = TERM_CAP;
				clamp_flag = 1;
			end
			return neg ? -longint'(m) : longint'(m);
		endfunction

		function void note_input(logic [1:0] cmd, logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
			longint t[3], sum[3], dl[3], r[3], c[3], p, s, v;
			longint unsigned rr, rn;
			int j;
			bit sing;
			velocity_t e;
			t[0] = longint'(signed'(x));
			t[1] = longint'(signed'(y));
			t[2] = longint'(signed'(z));
			case (cmd)
				CMD_CLEAR: count = 0;
				CMD_LOAD: begin
					if (count < MAX_POINTS) begin
						for (int a = 0; a < 3; a++) pts[count][a] = t[a];
						count++;
					end
				end
				CMD_QUERY: begin
					clamp_flag = 0;
					sing = 0;
					for (int a = 0; a < 3; a++) sum[a] = 0;
					for (int i = 0; i < count; i++) begin
						j = (i + 1 < count) ? i + 1 : 0;
						rr = 0;
						for (int a = 0; a < 3; a++) begin
							dl[a] = clamp(pts[j][a] - pts[i][a], 64'sd2147483647);
							r[a] = clamp(t[a] - pts[i][a], 64'sd2147483647);
							rr += longint'(r[a] * r[a]);
						end
						if (rr == 0) begin
							sing = 1;
							continue;
						end
						rn = int_sqrt(rr);
						c[0] = dl[1] * r[2] - dl[2] * r[1];
						c[1] = dl[2] * r[0] - dl[0] * r[2];
						c[2] = dl[0] * r[1] - dl[1] * r[0];
						for (int a = 0; a < 3; a++) sum[a] += segment_term(c[a], rn);
					end
					p = round_shift(circulation * longint'(INV_4PI_Q30), 30);
					for (int a = 0; a < 3; a++) begin
						s = clamp(sum[a], longint'(TERM_CAP));
						v = clamp(round_shift(s * p, FRAC_BITS), 64'sd2147483647);
						if (a == 0) e.vx = v[31:0];
						else if (a == 1) e.vy = v[31:0];
						else e.vz = v[31:0];
					end
					e.sing = sing;
					e.sat = clamp_flag;
					e.full = count >= MAX_POINTS;
					expected.push_back(e);
				end
				default: ;
			endcase
		endfunction

		function void check_result(velocity_t got);
			velocity_t e;
			if (expected.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
				return;
			end
			e = expected.pop_front();
			if (got.vx !== e.vx) begin
				$display("%0t: vel_x expected %h actual %h", $realtime, e.vx, got.vx);
				errors++;
			end
			if (got.vy !== e.vy) begin
				$display("%0t: vel_y expected %h actual %h", $realtime, e.vy, got.vy);
				errors++;
			end
			if (got.vz !== e.vz) begin
				$display("%0t: vel_z expected %h actual %h", $realtime, e.vz, got.vz);
				errors++;
			end
			if (got.sing !== e.sing) begin
				$display("%0t: singular_seen expected %b actual %b", $realtime, e.sing,
					got.sing);
				errors++;
			end
			if (got.sat !== e.sat) begin
				$display("%0t: saturated expected %b actual %b", $realtime, e.sat, got.sat);
				errors++;
			end
			if (got.full !== e.full) begin
				$display("%0t: store_full expected %b actual %b", $realtime, e.full,
					got.full);
				errors++;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	localparam longint CYCLE_LIMIT = 20000000;

	logic clk = 0;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_data;

	pbsv_in_if in_ch();
	pbsv_out_if out_ch();

	polyline_biot_savart_velocity dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	velocity_scoreboard sb = new();
	bit idle_en = 1;
	bit hold_req = 0;
	int hold_left = 0;
	longint cycles = 0;
	int items = 0;
	int pc = 0;
	logic [31:0] lx[8], ly[8], lz[8];

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("polyline_biot_savart_velocity regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid && out_ch.ready)
			sb.check_result({out_ch.vel_x, out_ch.vel_y, out_ch.vel_z, out_ch.singular_seen,
				out_ch.saturated, out_ch.store_full});
		if (hold_req) begin
			hold_req = 0;
			hold_left = 30000;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 0;
		end else begin
			out_ch.ready <= !(idle_en && $urandom_range(99) < 18);
		end
	end

	task automatic send(logic [1:0] cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		if (idle_en && $urandom_range(99) < 18) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.command <= cmd;
		in_ch.coord_x <= x;
		in_ch.coord_y <= y;
		in_ch.coord_z <= z;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(cmd, x, y, z);
		items++;
		if (cmd == CMD_CLEAR) pc = 0;
		if (cmd == CMD_LOAD && pc < 8) begin
			lx[pc] = x;
			ly[pc] = y;
			lz[pc] = z;
			pc++;
		end
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_circulation(logic [31:0] v);
		drain();
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.circulation = longint'(signed'(v));
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			1: return $urandom;
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
		endcase
	endfunction

	task automatic query_random();
		int k;
		if (pc > 0 && $urandom_range(99) < 20) begin
			k = $urandom_range(pc - 1);
			send(CMD_QUERY, lx[k], ly[k], lz[k]);
		end else begin
			send(CMD_QUERY, rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_data = 0;
		in_ch.valid = 0;
		in_ch.command = CMD_CLEAR;
		in_ch.coord_x = 0;
		in_ch.coord_y = 0;
		in_ch.coord_z = 0;
		out_ch.ready = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(CMD_QUERY, 32'h0001_0000, 0, 0);
		send(CMD_LOAD, 32'h0001_0000, 0, 0);
		send(CMD_QUERY, 32'h0001_0000, 0, 0);
		send(CMD_QUERY, 0, 32'h0001_0000, 0);
		send(CMD_LOAD, 0, 32'h0001_0000, 0);
		send(CMD_LOAD, 0, 0, 32'h0001_0000);
		send(CMD_QUERY, 0, 0, 0);
		send(CMD_QUERY, 0, 32'h0001_0000, 0);
		send(CMD_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(CMD_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send(CMD_QUERY, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
		send(CMD_CLEAR, 0, 0, 0);
		send(CMD_QUERY, 0, 0, 0);
		send(CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send(CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(CMD_QUERY, 0, 0, 0);
		send(CMD_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send(CMD_CLEAR, 0, 0, 0);

		set_circulation(32'h7FFF_FFFF);
		send(CMD_LOAD, 0, 0, 0);
		send(CMD_LOAD, 32'h0000_0100, 0, 0);
		send(CMD_QUERY, 0, 32'h0000_0001, 0);
		set_circulation(32'h8000_0000);
		send(CMD_QUERY, 0, 32'h0000_0001, 0);
		set_circulation(0);
		send(CMD_QUERY, 0, 32'h0001_0000, 0);
		set_circulation(32'h0001_0000);

		while (items < 580) begin
			if (items >= 200 && items < 300) idle_en = 0;
			else idle_en = 1;
			if (items % 100 < 6 && sb.pending() == 0 && items > 30)
				set_circulation($urandom_range(3) == 0 ? $urandom :
					$urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
			if (pc >= 6 || $urandom_range(99) < 40)
				send(CMD_CLEAR, rand_coord(), rand_coord(), rand_coord());
			repeat ($urandom_range(1, 4)) send(CMD_LOAD, rand_coord(), rand_coord(),
				rand_coord());
			if (items >= 400 && items < 420 && hold_left == 0) begin
				hold_req = 1;
				repeat (4) query_random();
			end
			repeat ($urandom_range(1, 3)) query_random();
			if ($urandom_range(99) < 8) send(CMD_RSVD, $urandom, $urandom, $urandom);
			if ($urandom_range(99) < 5) drain();
		end

		drain();
		idle_en = 0;
		send(CMD_CLEAR, 0, 0, 0);
		for (int n = 0; n < MAX_POINTS; n++)
			send(CMD_LOAD, n << 12, (n % 7) << 14, (n % 5) << 13);
		send(CMD_LOAD, 32'h0FFF_0000, 0, 0);
		send(CMD_QUERY, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send(CMD_CLEAR, 0, 0, 0);
		send(CMD_QUERY, 0, 0, 0);
		idle_en = 1;

		in_ch.valid <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("polyline_biot_savart_velocity regression: pass");
		else
			$display("polyline_biot_savart_velocity regression: fail");
		$finish;
	end
endmodule

@@ polyline_biot_savart_velocity.f @@
hw/rtl/pbsv_pkg.sv
hw/rtl/pbsv_stream_if.sv
hw/rtl/pbsv_ram.sv
hw/rtl/pbsv_div.sv
hw/rtl/polyline_biot_savart_velocity.sv
tb/sv/polyline_biot_savart_velocity_test.sv
